[hdl/matrix4_chain_multiply_assert.svh]
// Assertion macros for the matrix chain multiplier.
// Used by matrix4_chain_multiply.sv; expects signals clk and rst in scope.
`ifndef MATRIX4_CHAIN_MULTIPLY_ASSERT_SVH
`define MATRIX4_CHAIN_MULTIPLY_ASSERT_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define MCM_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mcm assertion failed");

// Next-cycle implication, checked on every clock edge outside reset.
`define MCM_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mcm assertion failed");

`endif

[hdl/mcm_pkg.sv]
// Package for the matrix chain multiplier: widths, constants, payload types.
// No dependencies; used by mcm_dot4.sv and matrix4_chain_multiply.sv.
`default_nettype none

package mcm_pkg;

  localparam int DIM        = 4;
  localparam int ELEM_W     = 32;
  localparam int FRAC_W     = 5;
  localparam int COL_W      = 2;
  localparam int PROD_W     = 2 * ELEM_W;
  localparam int ACC_W      = PROD_W + 2;
  localparam logic [FRAC_W-1:0] FRAC_RESET = FRAC_W'(16);
  localparam logic [COL_W-1:0]  LAST_COL   = COL_W'(DIM - 1);

  typedef logic signed [ELEM_W-1:0] elem_t;
  typedef elem_t [DIM-1:0] elem_vec_t;

  // One input column with its chain position flags
  typedef struct packed {
    logic signed [ELEM_W-1:0] in_row0;
    logic signed [ELEM_W-1:0] in_row1;
    logic signed [ELEM_W-1:0] in_row2;
    logic signed [ELEM_W-1:0] in_row3;
    logic                     first_matrix;
    logic                     last_matrix;
  } col_item_t;

  // One product column of the final matrix
  typedef struct packed {
    logic signed [ELEM_W-1:0] out_row0;
    logic signed [ELEM_W-1:0] out_row1;
    logic signed [ELEM_W-1:0] out_row2;
    logic signed [ELEM_W-1:0] out_row3;
    logic [COL_W-1:0]         out_column;
    logic                     chain_done;
  } res_item_t;

endpackage

`default_nettype wire

[hdl/mcm_dot4.sv]
// Fixed-point dot product of one matrix row with one column: four signed
// multiplies, exact wide sum, arithmetic shift by frac, 32-bit saturation.
// Depends on mcm_pkg.
`default_nettype none

module mcm_dot4 (
  input  mcm_pkg::elem_vec_t            mat_row,
  input  mcm_pkg::elem_vec_t            vec,
  input  logic [mcm_pkg::FRAC_W-1:0]    frac,
  output mcm_pkg::elem_t                dot
);

  localparam logic signed [mcm_pkg::ACC_W-1:0] SAT_MAX =
    mcm_pkg::ACC_W'(signed'({1'b0, {(mcm_pkg::ELEM_W-1){1'b1}}}));
  localparam logic signed [mcm_pkg::ACC_W-1:0] SAT_MIN = ~SAT_MAX;

  logic signed [mcm_pkg::PROD_W-1:0] prod [mcm_pkg::DIM];
  logic signed [mcm_pkg::ACC_W-1:0]  acc;
  logic signed [mcm_pkg::ACC_W-1:0]  shifted;

  // Four independent products, full 64-bit width
  always_comb begin
    for (int k = 0; k < mcm_pkg::DIM; k++) begin
      prod[k] = mcm_pkg::PROD_W'(signed'(mat_row[k])) * mcm_pkg::PROD_W'(signed'(vec[k]));
    end
  end

  // Exact sum, then scale back to the element format
  always_comb begin
    acc = '0;
    for (int k = 0; k < mcm_pkg::DIM; k++) begin
      acc = acc + mcm_pkg::ACC_W'(prod[k]);
    end
    shifted = acc >>> frac;
  end

  // Clamp to the 32-bit range
  always_comb begin
    if (shifted > SAT_MAX) begin
      dot = SAT_MAX[mcm_pkg::ELEM_W-1:0];
    end else if (shifted < SAT_MIN) begin
      dot = SAT_MIN[mcm_pkg::ELEM_W-1:0];
    end else begin
      dot = shifted[mcm_pkg::ELEM_W-1:0];
    end
  end

endmodule

`default_nettype wire

[hdl/matrix4_chain_multiply.sv]
// Top level of the 4x4 matrix chain multiplier (column-major, signed fixed point).
// Depends on mcm_pkg, mcm_dot4 and matrix4_chain_multiply_assert.svh.
//
// Usage:
//   Columns enter on col_valid/col_ready/col_data, one column per transfer,
//   four per matrix; first_matrix and last_matrix mark the chain position.
//   Columns of the first matrix load the running product. Every other column
//   is multiplied by the running product; the fourth column of a matrix makes
//   the new product the running one. Only columns of the last matrix leave on
//   res_valid/res_ready/res_data, with their column index; chain_done marks
//   column 3. cfg_we/cfg_wdata set the fraction bits (reset 16); write only
//   while the block is idle.
//   A column in the input register is computed whole (sixteen multiplies, sums,
//   shift, clamp) and loaded into the output register when it moves on.
//   Throughput: one column per cycle unless the receiver stalls; the input
//   register and the output register each take one transfer per cycle.
//   Reset clears the column count, both valid flags and fraction bits; the
//   matrix contents are not cleared. When the receiver stalls, a result waits
//   in the output register, one more column waits in the input register, and
//   col_ready drops only while both are held.
`default_nettype none

module matrix4_chain_multiply (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          col_valid,
  output logic                          col_ready,
  input  mcm_pkg::col_item_t            col_data,
  output logic                          res_valid,
  input  logic                          res_ready,
  output mcm_pkg::res_item_t            res_data,
  input  logic                          cfg_we,
  input  logic [mcm_pkg::FRAC_W-1:0]    cfg_wdata
);

  `include "matrix4_chain_multiply_assert.svh"

  logic [mcm_pkg::FRAC_W-1:0] frac_bits;
  logic                       s1_valid;
  mcm_pkg::col_item_t         s1_item;
  logic                       s1_adv;
  logic [mcm_pkg::COL_W-1:0]  col_cnt;
  mcm_pkg::elem_vec_t         running [mcm_pkg::DIM];
  mcm_pkg::elem_vec_t         pending [mcm_pkg::DIM];
  mcm_pkg::elem_vec_t         s1_col;
  mcm_pkg::elem_vec_t         mat_rows [mcm_pkg::DIM];
  mcm_pkg::elem_vec_t         dots;
  mcm_pkg::elem_vec_t         res_col;
  mcm_pkg::res_item_t         res_next;

  // Fraction bits register
  always_ff @(posedge clk) begin
    if (rst) begin
      frac_bits <= mcm_pkg::FRAC_RESET;
    end else if (cfg_we) begin
      frac_bits <= cfg_wdata;
    end
  end

  // Input register: moves on when it makes no result or the output slot frees up
  assign s1_adv    = s1_valid && (!s1_item.last_matrix || !res_valid || res_ready);
  assign col_ready = !s1_valid || s1_adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (col_ready) begin
      s1_valid <= col_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (col_ready && col_valid) begin
      s1_item <= col_data;
    end
  end

  // Column count advances once per processed column
  always_ff @(posedge clk) begin
    if (rst) begin
      col_cnt <= '0;
    end else if (s1_adv) begin
      col_cnt <= col_cnt + 1'b1;
    end
  end

  assign s1_col[0] = s1_item.in_row0;
  assign s1_col[1] = s1_item.in_row1;
  assign s1_col[2] = s1_item.in_row2;
  assign s1_col[3] = s1_item.in_row3;

  // Row r of the running product, gathered across its columns
  always_comb begin
    for (int r = 0; r < mcm_pkg::DIM; r++) begin
      for (int k = 0; k < mcm_pkg::DIM; k++) begin
        mat_rows[r][k] = running[k][r];
      end
    end
  end

  for (genvar r = 0; r < mcm_pkg::DIM; r++) begin : g_row
    mcm_dot4 u_dot (
      .mat_row (mat_rows[r]),
      .vec     (s1_col),
      .frac    (frac_bits),
      .dot     (dots[r])
    );
  end

  assign res_col = s1_item.first_matrix ? s1_col : dots;

  // Running and pending products; the commit on column 3 takes the fresh column
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      if (s1_item.first_matrix) begin
        running[col_cnt] <= s1_col;
      end else begin
        pending[col_cnt] <= dots;
        if (col_cnt == mcm_pkg::LAST_COL) begin
          for (int j = 0; j < mcm_pkg::DIM; j++) begin
            running[j] <= (mcm_pkg::COL_W'(j) == col_cnt) ? dots : pending[j];
          end
        end
      end
    end
  end

  // Output register
  always_comb begin
    res_next.out_row0   = res_col[0];
    res_next.out_row1   = res_col[1];
    res_next.out_row2   = res_col[2];
    res_next.out_row3   = res_col[3];
    res_next.out_column = col_cnt;
    res_next.chain_done = (col_cnt == mcm_pkg::LAST_COL);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (s1_adv && s1_item.last_matrix) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv && s1_item.last_matrix) begin
      res_data <= res_next;
    end
  end

  // Checks
  `MCM_ASSERT_NOW(a_done_on_last_col, res_valid,
                  res_data.chain_done == (res_data.out_column == mcm_pkg::LAST_COL))
  `MCM_ASSERT_NEXT(a_result_loaded, s1_adv && s1_item.last_matrix, res_valid)
  `MCM_ASSERT_NEXT(a_count_steps, s1_adv, col_cnt == $past(col_cnt) + 1'b1)
  `MCM_ASSERT_NOW(a_ready_when_empty, !s1_valid, col_ready)

endmodule

`default_nettype wire
